### rtl/spme_pkg.sv
// ============================================================================
// spme_pkg
// Shared types, constants and fixed-point helpers of the pose matrix engine.
// ============================================================================
package spme_pkg;

    localparam int MAX_JOINTS = 256;
    localparam int JW         = $clog2(MAX_JOINTS);
    localparam int ROW_DEPTH  = MAX_JOINTS * 3;
    localparam int RAW        = $clog2(ROW_DEPTH);
    localparam int QDEPTH     = 2;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int PAW        = 1;
    localparam int PCW        = 5;

    localparam logic signed [49:0] QONE    = 50'sd65536;
    localparam logic signed [49:0] SAT_MAX = 50'sd2147483647;
    localparam logic signed [49:0] SAT_MIN = -50'sd2147483648;

    localparam logic [PAW-1:0] ADDR_WORLD_MODE = '0;

    typedef enum logic [1:0] {
        KIND_POSE   = 2'd0,
        KIND_BIND   = 2'd1,
        KIND_INV    = 2'd2,
        KIND_PARENT = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t           kind;
        logic [JW-1:0]   joint;
        logic [1:0]      row;
        logic            par_ok;
        logic [JW-1:0]   par;
        logic [3:0][31:0] q;
        logic [2:0][31:0] s;
        logic [2:0][31:0] t;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef enum logic [2:0] {
        OP_JM,
        OP_LD,
        OP_MM,
        OP_T2A,
        OP_T2B,
        OP_WR,
        OP_WCHK,
        OP_EMIT
    } op_t;

    typedef enum logic [1:0] {
        SRC_BIND,
        SRC_INV,
        SRC_POSE
    } src_t;

    typedef struct packed {
        op_t            op;
        src_t           src;
        logic           use_par;
        logic           dst_b;
        logic [PCW-1:0] next;
    } uop_t;

    localparam logic [PCW-1:0] PC_PARENT = 5'd0;
    localparam logic [PCW-1:0] PC_ROOT   = 5'd9;
    localparam logic [PCW-1:0] PC_EMIT   = 5'd17;

    // Sequence of matrix steps for one pose transaction.
    function automatic uop_t uop(input logic [PCW-1:0] pc);
        uop_t u;
        u = '{op: OP_EMIT, src: SRC_BIND, use_par: 1'b0, dst_b: 1'b0, next: PC_EMIT};
        unique case (pc)
            5'd0:  u = '{OP_JM,   SRC_BIND, 1'b0, 1'b1, 5'd1};
            5'd1:  u = '{OP_LD,   SRC_BIND, 1'b1, 1'b0, 5'd2};
            5'd2:  u = '{OP_MM,   SRC_BIND, 1'b0, 1'b0, 5'd3};
            5'd3:  u = '{OP_T2A,  SRC_BIND, 1'b0, 1'b0, 5'd4};
            5'd4:  u = '{OP_LD,   SRC_INV,  1'b0, 1'b1, 5'd5};
            5'd5:  u = '{OP_MM,   SRC_BIND, 1'b0, 1'b0, 5'd6};
            5'd6:  u = '{OP_T2B,  SRC_BIND, 1'b0, 1'b0, 5'd7};
            5'd7:  u = '{OP_LD,   SRC_POSE, 1'b1, 1'b0, 5'd8};
            5'd8:  u = '{OP_MM,   SRC_BIND, 1'b0, 1'b0, 5'd12};
            5'd9:  u = '{OP_JM,   SRC_BIND, 1'b0, 1'b0, 5'd10};
            5'd10: u = '{OP_LD,   SRC_INV,  1'b0, 1'b1, 5'd11};
            5'd11: u = '{OP_MM,   SRC_BIND, 1'b0, 1'b0, 5'd12};
            5'd12: u = '{OP_WR,   SRC_BIND, 1'b0, 1'b0, 5'd13};
            5'd13: u = '{OP_WCHK, SRC_BIND, 1'b0, 1'b0, 5'd14};
            5'd14: u = '{OP_T2A,  SRC_BIND, 1'b0, 1'b0, 5'd15};
            5'd15: u = '{OP_LD,   SRC_BIND, 1'b0, 1'b1, 5'd16};
            5'd16: u = '{OP_MM,   SRC_BIND, 1'b0, 1'b0, 5'd17};
            default: u = '{OP_EMIT, SRC_BIND, 1'b0, 1'b0, PC_EMIT};
        endcase
        return u;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
            r = 32'sh7fffffff;
        else if (v < SAT_MIN)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Q16.16 product with floor rounding.
    function automatic logic signed [49:0] qshift(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> 16;
        return s[49:0];
    endfunction

    function automatic logic [RAW-1:0] row_addr(input logic [JW-1:0] j,
                                                 input logic [1:0] r);
        return RAW'({j, 1'b0}) + RAW'(j) + RAW'(r);
    endfunction

    function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] k);
        return 4'({r, 1'b0}) + 4'(r) + 4'(k);
    endfunction

endpackage

### rtl/spme_front.sv
// ============================================================================
// spme_front
// Accepts input transactions, drops the ones that have no effect, classifies
// the rest and holds them in a short queue for the back end.
// ============================================================================
module spme_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           action,
    input  logic [7:0]           joint,
    input  logic signed [31:0]   rot_x,
    input  logic signed [31:0]   rot_y,
    input  logic signed [31:0]   rot_z,
    input  logic signed [31:0]   rot_w,
    input  logic signed [31:0]   scale_x,
    input  logic signed [31:0]   scale_y,
    input  logic signed [31:0]   scale_z,
    input  logic signed [31:0]   trans_x,
    input  logic signed [31:0]   trans_y,
    input  logic signed [31:0]   trans_z,
    output spme_pkg::head_t      head,
    input  logic                 pop
);
    import spme_pkg::*;

    item_t          entry_reg [QDEPTH];
    logic [QAW-1:0] wp_reg, wp_next;
    logic [QAW-1:0] rp_reg, rp_next;
    logic [QAW:0]   cnt_reg, cnt_next;
    item_t          cls;
    logic           keep;
    logic           push;

    always_comb
    begin
        logic joint_ok;
        logic row_ok;
        joint_ok   = {24'd0, joint} < 32'(MAX_JOINTS);
        row_ok     = (scale_x >= 32'sd0) && (scale_x <= 32'sd2);
        cls.kind   = kind_t'(action);
        cls.joint  = joint[JW-1:0];
        cls.row    = scale_x[1:0];
        cls.par_ok = (scale_x >= 32'sd0) && (scale_x < 32'(MAX_JOINTS));
        cls.par    = scale_x[JW-1:0];
        cls.q      = {rot_w, rot_z, rot_y, rot_x};
        cls.s      = {scale_z, scale_y, scale_x};
        cls.t      = {trans_z, trans_y, trans_x};
        unique case (cls.kind)
            KIND_BIND, KIND_INV: keep = joint_ok && row_ok;
            default:             keep = joint_ok;
        endcase
    end

    assign busy = (cnt_reg == (QAW+1)'(QDEPTH));
    assign push = start && !busy && keep;

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
            wp_next = (wp_reg == QAW'(QDEPTH - 1)) ? '0 : wp_reg + 1'b1;
        if (pop)
            rp_next = (rp_reg == QAW'(QDEPTH - 1)) ? '0 : rp_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wp_reg] <= cls;
    end

    assign head.valid = (cnt_reg != '0);
    assign head.item  = entry_reg[rp_reg];

endmodule

### rtl/spme_back.sv
// ============================================================================
// spme_back
// Executes queued transactions: table loads, the joint matrix and the chain
// of 3x4 products on three shared multipliers, then emits three rows.
// ============================================================================
module spme_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               world_mode,
    input  spme_pkg::head_t    head,
    output logic               pop,
    output logic               strobe,
    output logic [7:0]         out_joint,
    output logic [1:0]         out_row,
    output logic signed [31:0] col0,
    output logic signed [31:0] col1,
    output logic signed [31:0] col2,
    output logic signed [31:0] col3,
    output logic               last
);
    import spme_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_PAR  = 9'b000000010,
        ST_JA   = 9'b000000100,
        ST_JB   = 9'b000001000,
        ST_JC   = 9'b000010000,
        ST_LD   = 9'b000100000,
        ST_MM   = 9'b001000000,
        ST_MOVE = 9'b010000000,
        ST_EMIT = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [PCW-1:0]    pc_reg, pc_next;
    logic [3:0]        cnt_reg, cnt_next;
    item_t             item_reg, item_next;
    logic [JW-1:0]     par_reg, par_next;
    logic [11:0][31:0] a_reg, a_next;
    logic [11:0][31:0] b_reg, b_next;
    logic [11:0][31:0] t_reg, t_next;
    logic [8:0][31:0]  dq_reg, dq_next;
    logic [8:0][31:0]  u_reg, u_next;
    logic signed [63:0] prod_reg [3];
    logic signed [31:0] ma [3];
    logic signed [31:0] mb [3];

    logic              par_valid_reg [MAX_JOINTS];
    logic [JW-1:0]     par_mem [MAX_JOINTS];
    logic [JW-1:0]     par_rd_reg;
    logic              par_ok_reg;

    logic [127:0]      bind_mem [ROW_DEPTH];
    logic [127:0]      inv_mem  [ROW_DEPTH];
    logic [127:0]      pose_mem [ROW_DEPTH];
    logic [127:0]      bind_rd_reg, inv_rd_reg, pose_rd_reg;
    logic [RAW-1:0]    rd_addr;
    logic [RAW-1:0]    ld_addr;
    logic [RAW-1:0]    wr_addr;
    logic [127:0]      wr_data;
    logic              bind_we, inv_we, pose_we, par_we;

    logic              strobe_reg, strobe_next;
    logic [1:0]        row_reg, row_next;
    logic [3:0][31:0]  orow_reg, orow_next;

    uop_t              cur;

    function automatic state_t st_of(input op_t op);
        state_t s;
        unique case (op)
            OP_JM:   s = ST_JA;
            OP_LD:   s = ST_LD;
            OP_MM:   s = ST_MM;
            OP_EMIT: s = ST_EMIT;
            default: s = ST_MOVE;
        endcase
        return s;
    endfunction

    assign cur = uop(pc_reg);
    assign pop = (state_reg == ST_IDLE) && head.valid;

    assign ld_addr = row_addr(head.item.joint, head.item.row);
    assign bind_we = pop && (head.item.kind == KIND_BIND);
    assign inv_we  = pop && (head.item.kind == KIND_INV);
    assign par_we  = pop && (head.item.kind == KIND_PARENT);
    assign pose_we = (state_reg == ST_MOVE) && (cur.op == OP_WR);
    assign wr_addr = row_addr(item_reg.joint, cnt_reg[1:0]);
    assign rd_addr = row_addr(cur.use_par ? par_reg : item_reg.joint, cnt_reg[1:0]);

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            wr_data[k*32 +: 32] = t_reg[idx3(2'd0, 2'd0) + 4'({cnt_reg[1:0], 2'(k)})];
    end

    // Multiplier operand selection.
    always_comb
    begin
        logic [1:0] r;
        logic [1:0] c;
        r = cnt_reg[3:2];
        c = cnt_reg[1:0];
        for (int k = 0; k < 3; k++)
        begin
            ma[k] = '0;
            mb[k] = '0;
        end
        unique case (state_reg)
            ST_JA:
            begin
                unique case (cnt_reg[1:0])
                    2'd0:
                    begin
                        ma[0] = item_reg.q[0]; mb[0] = item_reg.q[0];
                        ma[1] = item_reg.q[1]; mb[1] = item_reg.q[1];
                        ma[2] = item_reg.q[2]; mb[2] = item_reg.q[2];
                    end
                    2'd1:
                    begin
                        ma[0] = item_reg.q[0]; mb[0] = item_reg.q[1];
                        ma[1] = item_reg.q[0]; mb[1] = item_reg.q[2];
                        ma[2] = item_reg.q[1]; mb[2] = item_reg.q[2];
                    end
                    2'd2:
                    begin
                        ma[0] = item_reg.q[3]; mb[0] = item_reg.q[0];
                        ma[1] = item_reg.q[3]; mb[1] = item_reg.q[1];
                        ma[2] = item_reg.q[3]; mb[2] = item_reg.q[2];
                    end
                    default: ;
                endcase
            end
            ST_JC:
            begin
                if (cnt_reg < 4'd3)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        ma[k] = item_reg.s[cnt_reg[1:0]];
                        mb[k] = u_reg[idx3(cnt_reg[1:0], 2'(k))];
                    end
                end
            end
            ST_MM:
            begin
                if (cnt_reg < 4'd12)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        ma[k] = a_reg[{r, 2'(k)}];
                        mb[k] = b_reg[{2'(k), c}];
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        logic [3:0]          e;
        logic [1:0]          g;
        logic signed [49:0]  sum;
        logic [PCW-1:0]      npc;
        logic                done;
        logic [3:0][31:0]    rdv;
        logic signed [31:0]  xx, yy, zz, xy, xz, yz, wx, wy, wz;

        state_next  = state_reg;
        pc_next     = pc_reg;
        cnt_next    = cnt_reg + 1'b1;
        item_next   = item_reg;
        par_next    = par_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        t_next      = t_reg;
        dq_next     = dq_reg;
        u_next      = u_reg;
        strobe_next = 1'b0;
        row_next    = row_reg;
        orow_next   = orow_reg;
        done        = 1'b0;
        npc         = cur.next;
        e           = cnt_reg - 1'b1;
        g           = e[1:0];
        sum         = '0;
        xx = dq_reg[0]; yy = dq_reg[1]; zz = dq_reg[2];
        xy = dq_reg[3]; xz = dq_reg[4]; yz = dq_reg[5];
        wx = dq_reg[6]; wy = dq_reg[7]; wz = dq_reg[8];

        unique case (cur.src)
            SRC_INV:  rdv = inv_rd_reg;
            SRC_POSE: rdv = pose_rd_reg;
            default:  rdv = bind_rd_reg;
        endcase

        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (pop && head.item.kind == KIND_POSE)
                begin
                    item_next  = head.item;
                    state_next = ST_PAR;
                end
            end
            ST_PAR:
            begin
                par_next   = par_rd_reg;
                pc_next    = par_ok_reg ? PC_PARENT : PC_ROOT;
                state_next = ST_JA;
                cnt_next   = '0;
            end
            ST_JA:
            begin
                if (cnt_reg != 4'd0)
                begin
                    for (int k = 0; k < 3; k++)
                        dq_next[idx3(g, 2'(k))] = sat32(qshift(prod_reg[k]) <<< 1);
                end
                if (cnt_reg == 4'd3)
                begin
                    state_next = ST_JB;
                    cnt_next   = '0;
                end
            end
            ST_JB:
            begin
                u_next[0] = sat32(QONE - 50'(sat32(50'(yy) + 50'(zz))));
                u_next[1] = sat32(50'(xy) - 50'(wz));
                u_next[2] = sat32(50'(xz) + 50'(wy));
                u_next[3] = sat32(50'(xy) + 50'(wz));
                u_next[4] = sat32(QONE - 50'(sat32(50'(xx) + 50'(zz))));
                u_next[5] = sat32(50'(yz) - 50'(wx));
                u_next[6] = sat32(50'(xz) - 50'(wy));
                u_next[7] = sat32(50'(yz) + 50'(wx));
                u_next[8] = sat32(QONE - 50'(sat32(50'(xx) + 50'(yy))));
                state_next = ST_JC;
                cnt_next   = '0;
            end
            ST_JC:
            begin
                if (cnt_reg != 4'd0)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (cur.dst_b)
                            b_next[{g, 2'(k)}] = sat32(qshift(prod_reg[k]));
                        else
                            a_next[{g, 2'(k)}] = sat32(qshift(prod_reg[k]));
                    end
                    if (cur.dst_b)
                        b_next[{g, 2'd3}] = item_reg.t[g];
                    else
                        a_next[{g, 2'd3}] = item_reg.t[g];
                end
                done = (cnt_reg == 4'd3);
            end
            ST_LD:
            begin
                if (cnt_reg != 4'd0)
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        if (cur.dst_b)
                            b_next[{g, 2'(k)}] = rdv[k];
                        else
                            a_next[{g, 2'(k)}] = rdv[k];
                    end
                end
                done = (cnt_reg == 4'd3);
            end
            ST_MM:
            begin
                if (cnt_reg != 4'd0)
                begin
                    sum = qshift(prod_reg[0]) + qshift(prod_reg[1]) + qshift(prod_reg[2]);
                    // Column 3 carries the translation of the left operand.
                    if (e[1:0] == 2'd3)
                        sum = sum + 50'($signed(a_reg[{e[3:2], 2'd3}]));
                    t_next[e] = sat32(sum);
                end
                done = (cnt_reg == 4'd12);
            end
            ST_MOVE:
            begin
                unique case (cur.op)
                    OP_T2A:  begin a_next = t_reg; done = 1'b1; end
                    OP_T2B:  begin b_next = t_reg; done = 1'b1; end
                    OP_WCHK:
                    begin
                        if (!world_mode)
                            npc = PC_EMIT;
                        done = 1'b1;
                    end
                    default: done = (cnt_reg == 4'd2);
                endcase
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                row_next    = cnt_reg[1:0];
                for (int k = 0; k < 4; k++)
                    orow_next[k] = t_reg[{cnt_reg[1:0], 2'(k)}];
                if (cnt_reg == 4'd2)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (done)
        begin
            pc_next    = npc;
            state_next = st_of(uop(npc).op);
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pc_reg     <= '0;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
            for (int i = 0; i < MAX_JOINTS; i++)
                par_valid_reg[i] <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            pc_reg     <= pc_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
            if (par_we)
                par_valid_reg[head.item.joint] <= head.item.par_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        par_reg  <= par_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        t_reg    <= t_next;
        dq_reg   <= dq_next;
        u_reg    <= u_next;
        row_reg  <= row_next;
        orow_reg <= orow_next;
        for (int k = 0; k < 3; k++)
            prod_reg[k] <= 64'(ma[k]) * 64'(mb[k]);
        par_ok_reg <= par_valid_reg[head.item.joint];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
            par_mem[head.item.joint] <= head.item.par;
        par_rd_reg <= par_mem[head.item.joint];
    end

    always_ff @(posedge clk)
    begin
        if (bind_we)
            bind_mem[ld_addr] <= head.item.q;
        bind_rd_reg <= bind_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (inv_we)
            inv_mem[ld_addr] <= head.item.q;
        inv_rd_reg <= inv_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pose_we)
            pose_mem[wr_addr] <= wr_data;
        pose_rd_reg <= pose_mem[rd_addr];
    end

    assign strobe    = strobe_reg;
    assign out_joint = 8'(item_reg.joint);
    assign out_row   = row_reg;
    assign col0      = orow_reg[0];
    assign col1      = orow_reg[1];
    assign col2      = orow_reg[2];
    assign col3      = orow_reg[3];
    assign last      = (row_reg == 2'd2);

endmodule

### rtl/skeletal_pose_matrix_engine.sv
// ============================================================================
// skeletal_pose_matrix_engine
// Pose items are handled one at a time: the back end takes no new item until the
// rows of the current pose have left, and its three rows follow back to back.
// Loads are written into the tables as they are popped; a pose holds the three shared
// multipliers until it is emitted, and a parent and world mode each add matrix steps.
// The receiver cannot stall the results. Reset clears the parent table and world_mode.
// ============================================================================
module skeletal_pose_matrix_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [spme_pkg::PAW-1:0]        paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      action,
    input  logic [7:0]                      joint,
    input  logic signed [31:0]              rot_x,
    input  logic signed [31:0]              rot_y,
    input  logic signed [31:0]              rot_z,
    input  logic signed [31:0]              rot_w,
    input  logic signed [31:0]              scale_x,
    input  logic signed [31:0]              scale_y,
    input  logic signed [31:0]              scale_z,
    input  logic signed [31:0]              trans_x,
    input  logic signed [31:0]              trans_y,
    input  logic signed [31:0]              trans_z,
    output logic                            strobe,
    output logic [7:0]                      out_joint,
    output logic [1:0]                      out_row,
    output logic signed [31:0]              col0,
    output logic signed [31:0]              col1,
    output logic signed [31:0]              col2,
    output logic signed [31:0]              col3,
    output logic                            last
);
    import spme_pkg::*;

    logic  world_mode_reg;
    head_t head;
    logic  pop;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_WORLD_MODE) ? {31'd0, world_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            world_mode_reg <= 1'b0;
        else if (psel && penable && pwrite && pready && paddr == ADDR_WORLD_MODE)
            world_mode_reg <= pwdata[0];
    end

    spme_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .action  (action),
        .joint   (joint),
        .rot_x   (rot_x),
        .rot_y   (rot_y),
        .rot_z   (rot_z),
        .rot_w   (rot_w),
        .scale_x (scale_x),
        .scale_y (scale_y),
        .scale_z (scale_z),
        .trans_x (trans_x),
        .trans_y (trans_y),
        .trans_z (trans_z),
        .head    (head),
        .pop     (pop)
    );

    spme_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .world_mode (world_mode_reg),
        .head       (head),
        .pop        (pop),
        .strobe     (strobe),
        .out_joint  (out_joint),
        .out_row    (out_row),
        .col0       (col0),
        .col1       (col1),
        .col2       (col2),
        .col3       (col3),
        .last       (last)
    );

    // The three rows of a pose leave on consecutive cycles.
    a_rows_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("pose rows not consecutive");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("result right after last row");

    a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> out_row == $past(out_row) + 2'd1)
        else $error("row numbers out of order");

    a_last_on_row2: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (last == (out_row == 2'd2)))
        else $error("last flag does not match row two");

endmodule
